// ===== design/sine_oscillator_with_release_defines.svh =====
// Assertion macros used by the checker file of the sine oscillator.
`ifndef SINE_OSCILLATOR_WITH_RELEASE_DEFINES_SVH
`define SINE_OSCILLATOR_WITH_RELEASE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define SOWR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define SOWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sowr_pkg.sv =====
// Package with types, constants and the sine table of the sine oscillator.
package sowr_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QTR_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned QIDX_W = SINE_TABLE_BITS - 1;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam int unsigned SR_W = 18;
  localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [15:0] AMP_MAX = 16'd32768;

  localparam int unsigned DIV_W = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_NOTE = 2'd1;
  localparam logic [1:0] REQ_REL = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTE,
    OP_REL,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [23:0] freq;
    logic [15:0] amp;
    logic [15:0] phase;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  typedef logic [15:0] qtab_t [QTR_LEN+1];

  // Unsigned long division, one quotient bit per loop pass.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave table in Q1.15, from a Q30 Taylor series of degree 15.
  function automatic qtab_t build_qtab();
    qtab_t           t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    for (int unsigned i = 0; i <= QTR_LEN; i++) begin
      x = (PI_Q30 * longint'(i)) >> (SINE_TABLE_BITS - 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (longint unsigned k = 1; k <= 7; k++) begin
        term = div_u64((term * x2) >> 30, (2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = ($unsigned(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      t[i] = 16'(r);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// ===== design/sowr_front.sv =====
// Front end: accepts items, classifies them and holds them in a short queue.
module sowr_front import sowr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [23:0] note_frequency_i,
  input  logic [15:0] note_amplitude_i,
  input  logic [15:0] start_phase_i,
  output logic        head_valid_o,
  output item_t       head_o,
  input  logic        pop_i
);

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entry_q [QUEUE_DEPTH];
  item_t             item;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  always_comb begin
    item.freq = note_frequency_i;
    item.phase = start_phase_i;
    item.amp = (note_amplitude_i > AMP_MAX) ? AMP_MAX : note_amplitude_i;
    case (req_type_i)
      REQ_TICK: item.op = OP_TICK;
      REQ_NOTE: item.op = OP_NOTE;
      REQ_REL:  item.op = OP_REL;
      default:  item.op = OP_NOP;
    endcase
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop = pop_i && head_valid_o;
  assign head_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== design/sowr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module sowr_div import sowr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SR_W-1:0]      rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [SR_W-1:0]      dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [SR_W:0]        shifted;
  logic [SR_W:0]        diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge = (shifted >= {1'b0, dvs_q});
  assign diff = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SR_W-1:0] : shifted[SR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q[31:0];

endmodule

// ===== design/sowr_back.sv =====
// Back end: oscillator state, sample computation and the output register.
module sowr_back import sowr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SR_W-1:0]    cfg_wdata_i,
  input  logic               head_valid_i,
  input  item_t              head_i,
  output logic               pop_o,
  output div_req_t           div_req_o,
  input  div_rsp_t           div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               active_o
);

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_RELEASING = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [SR_W-1:0]    sr_q;
  logic [31:0]        phase_q, phase_d;
  logic [31:0]        step_q, step_d;
  logic [31:0]        level_q, level_d;
  logic [31:0]        decay_q, decay_d;
  logic [47:0]        prod_q, prod_d;
  logic               neg_q, neg_d;
  logic               div_note_q, div_note_d;
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               active_q;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QIDX_W-1:0]          pos;
  logic [QIDX_W-1:0]          tab_addr;
  logic [15:0]                sine;
  logic [SR_W-1:0]            half;
  logic [16:0]                mag;
  logic [15:0]                sat;
  logic [15:0]                sample_tick;
  logic                       can_start;
  logic                       res_we;
  logic [15:0]                res_sample;
  logic                       res_active;

  assign idx = phase_q[31 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign pos = {1'b0, idx[SINE_TABLE_BITS-3:0]};
  assign tab_addr = quad[0] ? (QIDX_W'(QTR_LEN) - pos) : pos;
  assign sine = QTAB[tab_addr];
  assign half = (sr_q[SR_W-1:1] == '0) ? SR_W'(1) : {1'b0, sr_q[SR_W-1:1]};

  assign mag = prod_q[47:31];
  assign sat = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
  assign sample_tick = neg_q ? (16'd0 - sat) : sat;

  assign can_start = (state_q == ST_IDLE) && head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    phase_d = phase_q;
    step_d = step_q;
    level_d = level_q;
    decay_d = decay_q;
    prod_d = prod_q;
    neg_d = neg_q;
    div_note_d = div_note_q;
    pop_o = 1'b0;
    div_req_o = '0;
    res_we = 1'b0;
    res_sample = '0;
    res_active = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (can_start) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_TICK: begin
              if (mode_q != MODE_OFF) begin
                prod_d = level_q * sine;
                neg_d = quad[1];
                phase_d = phase_q + step_q;
                if (mode_q == MODE_RELEASING) begin
                  if (level_q <= decay_q) begin
                    level_d = '0;
                    mode_d = MODE_OFF;
                  end else begin
                    level_d = level_q - decay_q;
                  end
                end
                state_d = ST_TICK;
              end else begin
                res_we = 1'b1;
              end
            end
            OP_NOTE: begin
              level_d = {head_i.amp, 16'd0};
              phase_d = {head_i.phase, 16'd0};
              decay_d = '0;
              mode_d = MODE_PLAYING;
              if (sr_q == '0) begin
                step_d = '0;
                res_we = 1'b1;
                res_active = 1'b1;
              end else begin
                div_req_o.start = 1'b1;
                div_req_o.dividend = {head_i.freq, 24'd0};
                div_req_o.divisor = sr_q;
                div_note_d = 1'b1;
                state_d = ST_DIV;
              end
            end
            OP_REL: begin
              div_req_o.start = 1'b1;
              div_req_o.dividend = {16'd0, level_q};
              div_req_o.divisor = half;
              div_note_d = 1'b0;
              mode_d = MODE_RELEASING;
              state_d = ST_DIV;
            end
            default: begin
              res_we = 1'b1;
              res_active = (mode_q != MODE_OFF);
            end
          endcase
        end
      end
      ST_TICK: begin
        res_we = 1'b1;
        res_sample = sample_tick;
        res_active = (mode_q != MODE_OFF);
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          if (div_note_q) begin
            step_d = div_rsp_i.quotient;
          end else begin
            decay_d = (div_rsp_i.quotient == '0) ? 32'd1 : div_rsp_i.quotient;
          end
          res_we = 1'b1;
          res_active = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= MODE_OFF;
      sr_q <= SAMPLE_RATE_RST;
      phase_q <= '0;
      step_q <= '0;
      level_q <= '0;
      decay_q <= '0;
      div_note_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      phase_q <= phase_d;
      step_q <= step_d;
      level_q <= level_d;
      decay_q <= decay_d;
      div_note_q <= div_note_d;
      if (cfg_we_i) begin
        sr_q <= cfg_wdata_i;
      end
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q <= neg_d;
    if (res_we) begin
      sample_q <= res_sample;
      active_q <= res_active;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o = sample_q;
  assign active_o = active_q;

endmodule

// ===== design/sine_oscillator_with_release.sv =====
// Sine oscillator with linear release: accepts tick, note_on and release items and
// returns one sample item for each. A two-entry queue takes items while the back end
// works, so the input stalls only when two items are waiting. From the queue head a
// tick is a table lookup and one 32x16 multiply, then scaling. A note_on and a
// release each use the shared restoring divider, which yields one quotient bit per
// cycle over 48 bits; a note_on with a sample rate of zero skips the divider. The
// sample_rate register is written through cfg_we_i and cfg_wdata_i and must only
// change while no item is in flight.
module sine_oscillator_with_release import sowr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SR_W-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [23:0]        note_frequency_i,
  input  logic [15:0]        note_amplitude_i,
  input  logic [15:0]        start_phase_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               active_o
);

  item_t    head;
  logic     head_valid;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  sowr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .note_frequency_i(note_frequency_i),
    .note_amplitude_i(note_amplitude_i),
    .start_phase_i   (start_phase_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  sowr_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  sowr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .active_o    (active_o)
  );

endmodule

// ===== design/sowr_checker.sv =====
// Port-level checker for the sine oscillator and its bind to the top level.
`include "sine_oscillator_with_release_defines.svh"

module sowr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] sample_o,
  input logic        active_o
);

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Items accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `SOWR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_o) && $stable(active_o), "stalled result changed")
  `SOWR_ASSERT_IMPL(a_no_extra_result, out_valid_o, pending_q != 3'd0, "result without an item")
  `SOWR_ASSERT_IMPL(a_pending_bound, 1'b1, pending_q <= 3'd3, "too many items in flight")
  `SOWR_ASSERT_IMPL(a_ready_low_full, !in_ready_o, pending_q >= 3'd2, "input stalled while queue has room")

endmodule

bind sine_oscillator_with_release sowr_checker u_sowr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .sample_o   (sample_o),
  .active_o   (active_o)
);

// ===== tb/sine_oscillator_with_release_tb.sv =====
// Self-checking testbench for the sine oscillator with release, with a built-in predictor.
module sine_oscillator_with_release_tb;
  import sowr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD = 4;
  localparam int unsigned STIM_ITEMS = 600;
  localparam int unsigned NUM_RATES = 11;
  localparam int unsigned MAX_WAIT = 15;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum logic [1:0] {
    OSC_OFF,
    OSC_PLAYING,
    OSC_RELEASING
  } osc_mode_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
  } osc_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [SR_W-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = '0;
  logic [23:0]        note_frequency_i = '0;
  logic [15:0]        note_amplitude_i = '0;
  logic [15:0]        start_phase_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] sample_o;
  logic               active_o;

  item_t         pending_items[$];
  osc_result_t   expected_samples[$];
  item_t         in_item;
  logic [15:0]   quarter_sine [QTR_LEN+1];
  logic [SR_W-1:0] osc_rate;
  logic [31:0]   osc_phase;
  logic [31:0]   osc_step;
  logic [31:0]   osc_level;
  logic [31:0]   osc_decay;
  osc_mode_e     osc_mode;
  int unsigned   failures = 0;
  int unsigned   random_pushed = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   in_gap;
  int unsigned   out_stall;
  logic          drive_calm;
  logic          sink_calm;

  sine_oscillator_with_release i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .note_frequency_i (note_frequency_i),
    .note_amplitude_i (note_amplitude_i),
    .start_phase_i    (start_phase_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_o         (sample_o),
    .active_o         (active_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic record_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic advance_oscillator(input item_t it);
    logic [SINE_TABLE_BITS-1:0] idx;
    int unsigned                pos;
    logic [15:0]                sine;
    logic [15:0]                amp;
    logic [47:0]                quotient;
    logic [31:0]                half;
    longint unsigned            mag;
    osc_result_t                res;
    res.sample = '0;
    case (it.op)
      OP_TICK: begin
        if (osc_mode != OSC_OFF) begin
          idx = osc_phase[31 -: SINE_TABLE_BITS];
          pos = idx[SINE_TABLE_BITS-3:0];
          sine = idx[SINE_TABLE_BITS-2] ? quarter_sine[QTR_LEN - pos] : quarter_sine[pos];
          mag = (64'(osc_level) * 64'(sine)) >> 31;
          if (mag > 64'd32767) begin
            mag = 64'd32767;
          end
          res.sample = idx[SINE_TABLE_BITS-1] ? -16'(mag) : 16'(mag);
          osc_phase = osc_phase + osc_step;
          if (osc_mode == OSC_RELEASING) begin
            if (osc_level <= osc_decay) begin
              osc_level = '0;
              osc_mode = OSC_OFF;
            end else begin
              osc_level = osc_level - osc_decay;
            end
          end
        end
      end
      OP_NOTE: begin
        amp = (it.amp > AMP_MAX) ? AMP_MAX : it.amp;
        osc_level = {amp, 16'h0000};
        osc_phase = {it.phase, 16'h0000};
        quotient = (osc_rate != '0) ? {it.freq, 24'h000000} / 48'(osc_rate) : '0;
        osc_step = quotient[31:0];
        osc_decay = '0;
        osc_mode = OSC_PLAYING;
      end
      OP_REL: begin
        half = 32'(osc_rate >> 1);
        if (half == '0) begin
          half = 32'd1;
        end
        osc_decay = osc_level / half;
        if (osc_decay == '0) begin
          osc_decay = 32'd1;
        end
        osc_mode = OSC_RELEASING;
      end
      default: begin
      end
    endcase
    res.active = (osc_mode != OSC_OFF);
    expected_samples.push_back(res);
  endtask

  task automatic push_random(input op_e op);
    item_t it;
    it.op = op;
    it.phase = 16'($urandom());
    case ($urandom_range(0, 5))
      0: it.freq = '0;
      1: it.freq = '1;
      2: it.freq = 24'($urandom_range(20, 20000) << 8);
      default: it.freq = 24'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0: it.amp = '0;
      1: it.amp = 16'($urandom_range(1, 16));
      2: it.amp = AMP_MAX;
      3: it.amp = 16'($urandom());
      default: it.amp = 16'($urandom_range(0, 32768));
    endcase
    pending_items.push_back(it);
    random_pushed++;
  endtask

  task automatic wait_until_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed_requests
    item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= '0;
      note_frequency_i <= '0;
      note_amplitude_i <= '0;
      start_phase_i <= '0;
      in_item <= '0;
      in_gap <= 0;
      drive_calm <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_oscillator(in_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_item <= next_item;
          in_valid_i <= 1'b1;
          req_type_i <= next_item.op;
          note_frequency_i <= next_item.freq;
          note_amplitude_i <= next_item.amp;
          start_phase_i <= next_item.phase;
          in_gap <= drive_calm ? 0 : $urandom_range(0, MAX_WAIT);
          if ($urandom_range(0, 31) == 0) begin
            drive_calm <= !drive_calm;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : collect_samples
    osc_result_t want;
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
      sink_calm <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        record_failure($sformatf("unexpected item: sample %0d active %0b",
                                 sample_o, active_o));
      end else begin
        want = expected_samples.pop_front();
        if (sample_o !== want.sample) begin
          record_failure($sformatf("sample mismatch: expected %0d, got %0d",
                                   $signed(want.sample), sample_o));
        end
        if (active_o !== want.active) begin
          record_failure($sformatf("active mismatch: expected %0b, got %0b",
                                   want.active, active_o));
        end
      end
      stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        out_stall <= stall;
      end
      if ($urandom_range(0, 31) == 0) begin
        sink_calm <= !sink_calm;
      end
    end else if (!out_ready_i) begin
      if (out_stall <= 1) begin
        out_ready_i <= 1'b1;
      end else begin
        out_stall <= out_stall - 1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rnd;
    longint          sum;
    logic [SR_W-1:0] rates [NUM_RATES];
    int unsigned     target;

    for (int unsigned i = 0; i <= QTR_LEN; i++) begin
      x = (PI_Q30 * 64'(i)) >> (SINE_TABLE_BITS - 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (longint unsigned k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rnd = ($unsigned(sum) + 64'd16384) >> 15;
      if (rnd > 64'd32768) begin
        rnd = 64'd32768;
      end
      quarter_sine[i] = 16'(rnd);
    end
    osc_rate = SAMPLE_RATE_RST;
    osc_phase = '0;
    osc_step = '0;
    osc_level = '0;
    osc_decay = '0;
    osc_mode = OSC_OFF;

    rates = '{18'd48000, 18'd8000, 18'd192000, 18'd0, 18'd1, 18'd2, 18'd3, 18'h3FFFF,
              18'($urandom_range(4, 64)), 18'($urandom_range(4, 64)),
              18'($urandom_range(8000, 192000))};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_items.push_back(item_t'{OP_TICK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF});
    pending_items.push_back(item_t'{OP_NOP, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_REL, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOTE, 24'hFFFFFF, 16'hFFFF, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOTE, 24'h000000, 16'h8000, 16'h4000});
    pending_items.push_back(item_t'{OP_TICK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOP, 24'hFFFFFF, 16'hFFFF, 16'hFFFF});
    pending_items.push_back(item_t'{OP_NOTE, 24'h01B800, 16'h0000, 16'hFFFF});
    pending_items.push_back(item_t'{OP_REL, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOTE, 24'h000001, 16'h0001, 16'h8000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOTE, 24'h800000, 16'h8001, 16'hC000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_REL, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOTE, 24'h2BF200, 16'h7FFF, 16'h7FFF});
    pending_items.push_back(item_t'{OP_TICK, 24'h000000, 16'h0000, 16'h0000});
    pending_items.push_back(item_t'{OP_NOP, 24'h000000, 16'h0000, 16'h0000});

    for (int unsigned p = 0; p < NUM_RATES; p++) begin
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= rates[p];
      osc_rate = rates[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      target = (p + 1) * STIM_ITEMS / NUM_RATES;
      while (random_pushed < target) begin
        if ($urandom_range(0, 9) == 0) begin
          push_random(op_e'($urandom_range(0, 3)));
        end else begin
          if ($urandom_range(0, 7) != 0) begin
            push_random(OP_NOTE);
          end
          repeat ($urandom_range(0, 12)) push_random(OP_TICK);
          if ($urandom_range(0, 3) != 0) begin
            push_random(OP_REL);
            repeat ($urandom_range(0, 40)) push_random(OP_TICK);
          end
        end
      end
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
